// File: sv/slpq_pkg.sv
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared sizes, codes and transfer types of the sorted list priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package slpq_pkg;

	localparam int CAPACITY = 16;
	localparam int PAY_W    = 32;
	localparam int PRI_W    = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	// one more bit than an address so the null link fits
	localparam int IDX_W    = ADDR_W + 1;

	localparam logic [IDX_W-1:0] NIL     = IDX_W'(CAPACITY);
	localparam logic [IDX_W-1:0] CAP_CNT = IDX_W'(CAPACITY);

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                    kind;
		logic [PAY_W-1:0]        pay;
		logic signed [PRI_W-1:0] pri;
	} item_t;

	// store access from the sequencer: one read, one write per cycle
	typedef struct packed {
		logic [ADDR_W-1:0]       rd_addr;
		logic [ADDR_W-1:0]       wr_addr;
		logic                    wr_data_en;
		logic                    wr_link_en;
		logic [PAY_W-1:0]        wr_pay;
		logic signed [PRI_W-1:0] wr_pri;
		logic [IDX_W-1:0]        wr_link;
	} mem_req_t;

	typedef struct packed {
		logic [PAY_W-1:0]        pay;
		logic signed [PRI_W-1:0] pri;
		logic [IDX_W-1:0]        link;
	} mem_rd_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [PAY_W-1:0]        popped_payload;
		logic signed [PRI_W-1:0] popped_priority;
		logic [IDX_W-1:0]        entry_count;
		logic                    is_empty;
		logic                    is_full;
		logic [PAY_W-1:0]        front_payload;
		logic [PAY_W-1:0]        rear_payload;
	} res_t;

endpackage

`default_nettype wire

// File: sv/slpq_store.sv
// ----------------------------------------------------------------------------
// slpq_store
// Payload, priority and link arrays with one write and one registered read
// port. Link entries never written read as the reset chain i -> i+1.
// ----------------------------------------------------------------------------
`default_nettype none

module slpq_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slpq_pkg::mem_req_t req,
	output slpq_pkg::mem_rd_t      rd
);

	logic [slpq_pkg::PAY_W-1:0]        pay_mem  [slpq_pkg::CAPACITY];
	logic signed [slpq_pkg::PRI_W-1:0] pri_mem  [slpq_pkg::CAPACITY];
	logic [slpq_pkg::IDX_W-1:0]        link_mem [slpq_pkg::CAPACITY];
	logic [slpq_pkg::CAPACITY-1:0]     link_vld_q;

	logic [slpq_pkg::PAY_W-1:0]        rd_pay_q;
	logic signed [slpq_pkg::PRI_W-1:0] rd_pri_q;
	logic [slpq_pkg::IDX_W-1:0]        rd_link_q;
	logic [slpq_pkg::ADDR_W-1:0]       rd_addr_q;
	logic                              rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_data_en) begin
			pay_mem[req.wr_addr] <= req.wr_pay;
			pri_mem[req.wr_addr] <= req.wr_pri;
		end
		if (req.wr_link_en) begin
			link_mem[req.wr_addr] <= req.wr_link;
		end
		rd_pay_q  <= pay_mem[req.rd_addr];
		rd_pri_q  <= pri_mem[req.rd_addr];
		rd_link_q <= link_mem[req.rd_addr];
		rd_addr_q <= req.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (req.wr_link_en) begin
				link_vld_q[req.wr_addr] <= 1'b1;
			end
			rd_vld_q <= link_vld_q[req.rd_addr];
		end
	end

	always_comb begin
		rd.pay  = rd_pay_q;
		rd.pri  = rd_pri_q;
		// untouched slot: still on the initial free chain
		rd.link = rd_vld_q ? rd_link_q
			: ({1'b0, rd_addr_q} + slpq_pkg::IDX_W'(1));
	end

endmodule

`default_nettype wire

// File: sv/slpq_ctrl.sv
// ----------------------------------------------------------------------------
// slpq_ctrl
// Sequencer for push and pop: walks the ordered list one entry per cycle
// through the store read port and a single signed priority comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module slpq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire slpq_pkg::item_t     item,
	input  wire logic                out_free,
	output logic                     ready,
	output logic                     res_valid,
	output slpq_pkg::res_t           res,
	output slpq_pkg::mem_req_t       req,
	input  wire slpq_pkg::mem_rd_t   rd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_FREE  = 8'b0000_0010,
		ST_WALK  = 8'b0000_0100,
		ST_LINK  = 8'b0000_1000,
		ST_LINK2 = 8'b0001_0000,
		ST_POP   = 8'b0010_0000,
		ST_FRONT = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t                            state_q, state_d;
	logic [slpq_pkg::IDX_W-1:0]        head_q, head_d;
	logic [slpq_pkg::IDX_W-1:0]        tail_q, tail_d;
	logic [slpq_pkg::IDX_W-1:0]        free_q, free_d;
	logic [slpq_pkg::IDX_W-1:0]        count_q, count_d;

	slpq_pkg::item_t                   item_q;
	logic [slpq_pkg::IDX_W-1:0]        slot_q, cur_q, loc_q;
	logic [1:0]                        status_q;
	logic [slpq_pkg::PAY_W-1:0]        pop_pay_q, front_q, rear_q;
	logic signed [slpq_pkg::PRI_W-1:0] pop_pri_q;

	logic pri_less;
	logic slot_is_tail;

	// the shared comparator: new entry goes ahead of a strictly larger one
	assign pri_less     = item_q.pri < rd.pri;
	assign slot_is_tail = (loc_q == tail_q);

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		tail_d  = tail_q;
		free_d  = free_q;
		count_d = count_q;

		req            = '0;
		req.wr_pay     = item_q.pay;
		req.wr_pri     = item_q.pri;
		req.wr_addr    = slot_q[slpq_pkg::ADDR_W-1:0];
		req.rd_addr    = cur_q[slpq_pkg::ADDR_W-1:0];
		res_valid      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.kind == slpq_pkg::KIND_PUSH) begin
						req.rd_addr = free_q[slpq_pkg::ADDR_W-1:0];
						state_d = (count_q == slpq_pkg::CAP_CNT) ? ST_DONE : ST_FREE;
					end else begin
						req.rd_addr = head_q[slpq_pkg::ADDR_W-1:0];
						state_d = (count_q == '0) ? ST_DONE : ST_POP;
					end
				end
			end
			ST_FREE: begin
				free_d         = rd.link;
				req.wr_data_en = 1'b1;
				req.rd_addr    = head_q[slpq_pkg::ADDR_W-1:0];
				state_d        = (head_q == slpq_pkg::NIL) ? ST_LINK : ST_WALK;
			end
			ST_WALK: begin
				req.rd_addr = rd.link[slpq_pkg::ADDR_W-1:0];
				if (pri_less || rd.link == slpq_pkg::NIL) begin
					state_d = ST_LINK;
				end
			end
			ST_LINK: begin
				req.wr_link_en = 1'b1;
				req.wr_link    = cur_q;
				count_d        = count_q + slpq_pkg::IDX_W'(1);
				if (loc_q == slpq_pkg::NIL) begin
					head_d = slot_q;
					if (tail_q == slpq_pkg::NIL) begin
						tail_d = slot_q;
					end
					state_d = ST_DONE;
				end else begin
					state_d = ST_LINK2;
				end
			end
			ST_LINK2: begin
				req.wr_link_en = 1'b1;
				req.wr_addr    = loc_q[slpq_pkg::ADDR_W-1:0];
				req.wr_link    = slot_q;
				if (slot_is_tail) begin
					tail_d = slot_q;
				end
				state_d = ST_DONE;
			end
			ST_POP: begin
				// unlink head, give its slot back to the front of the free list
				req.wr_link_en = 1'b1;
				req.wr_link    = free_q;
				req.rd_addr    = rd.link[slpq_pkg::ADDR_W-1:0];
				free_d         = slot_q;
				head_d         = rd.link;
				count_d        = count_q - slpq_pkg::IDX_W'(1);
				if (rd.link == slpq_pkg::NIL) begin
					tail_d  = slpq_pkg::NIL;
					state_d = ST_DONE;
				end else begin
					state_d = ST_FRONT;
				end
			end
			ST_FRONT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= slpq_pkg::NIL;
			tail_q  <= slpq_pkg::NIL;
			free_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			free_q  <= free_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q    <= item;
					slot_q    <= (item.kind == slpq_pkg::KIND_PUSH) ? free_q : head_q;
					pop_pay_q <= '0;
					pop_pri_q <= '0;
					if (item.kind == slpq_pkg::KIND_PUSH) begin
						status_q <= (count_q == slpq_pkg::CAP_CNT)
							? slpq_pkg::STATUS_OVERFLOW : slpq_pkg::STATUS_OK;
					end else begin
						status_q <= (count_q == '0)
							? slpq_pkg::STATUS_UNDERFLOW : slpq_pkg::STATUS_OK;
					end
				end
			end
			ST_FREE: begin
				cur_q <= head_q;
				loc_q <= slpq_pkg::NIL;
			end
			ST_WALK: begin
				// advance past entries of equal or lower priority
				if (!pri_less) begin
					loc_q <= cur_q;
					cur_q <= rd.link;
				end
			end
			ST_LINK: begin
				if (loc_q == slpq_pkg::NIL) begin
					front_q <= item_q.pay;
					if (tail_q == slpq_pkg::NIL) begin
						rear_q <= item_q.pay;
					end
				end
			end
			ST_LINK2: begin
				if (slot_is_tail) begin
					rear_q <= item_q.pay;
				end
			end
			ST_POP: begin
				pop_pay_q <= rd.pay;
				pop_pri_q <= rd.pri;
			end
			ST_FRONT: begin
				front_q <= rd.pay;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign ready = (state_q == ST_IDLE);

	always_comb begin
		res.status          = status_q;
		res.popped_payload  = pop_pay_q;
		res.popped_priority = pop_pri_q;
		res.entry_count     = count_q;
		res.is_empty        = (count_q == '0);
		res.is_full         = (count_q == slpq_pkg::CAP_CNT);
		res.front_payload   = (head_q == slpq_pkg::NIL) ? '0 : front_q;
		res.rear_payload    = (tail_q == slpq_pkg::NIL) ? '0 : rear_q;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slpq_pkg::CAP_CNT)
		else $error("entry count beyond capacity");

	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (head_q == slpq_pkg::NIL))
		else $error("head pointer disagrees with entry count");

	a_tail_head: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q == slpq_pkg::NIL) == (head_q == slpq_pkg::NIL))
		else $error("tail pointer disagrees with head pointer");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (out_free && state_q == ST_DONE))
		else $error("result issued without room in output register");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cur_q != slpq_pkg::NIL))
		else $error("list walk past the null link");

endmodule

`default_nettype wire

// File: sv/sorted_list_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_top
// Ascending priority queue of 16 entries kept as an ordered linked list.
// ----------------------------------------------------------------------------
// Each input transfer is one operation (tuser 0 push, 1 pop) and gives exactly
// one result transfer with status, the popped entry, count, flags and the
// front and rear payloads. Equal priorities leave in arrival order. One item
// is in work at a time. An overflow or underflow goes straight to its result;
// a pop reads the head and, unless it empties the queue, the new front; a push
// takes a free slot, walks the list for its place, then writes its own link
// and, unless it lands at the head, the link of the entry before it. The list
// walk makes one store read and one priority compare per cycle. A finished
// result sits in the output register, and the next item is taken while it
// waits.
`default_nettype none

module sorted_list_priority_queue_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// payload [31:0], priority_req [47:32]
	input  wire logic [47:0]   s_tdata,
	// kind [0]
	input  wire logic          s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// popped_payload [31:0], popped_priority [47:32], entry_count [52:48],
	// is_empty [53], is_full [54], front_payload [86:55],
	// rear_payload [118:87], zero [119]
	output logic [119:0]       m_tdata,
	// status [1:0]
	output logic [1:0]         m_tuser
);

	slpq_pkg::item_t    item;
	slpq_pkg::res_t     res;
	slpq_pkg::res_t     res_q;
	slpq_pkg::mem_req_t req;
	slpq_pkg::mem_rd_t  rd;
	logic               ready;
	logic               res_valid;
	logic               out_free;
	logic               m_tvalid_q;

	assign item.kind = s_tuser;
	assign item.pay  = s_tdata[31:0];
	assign item.pri  = s_tdata[47:32];

	assign s_tready = ready;
	assign out_free = !m_tvalid_q || m_tready;

	slpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && ready),
		.item      (item),
		.out_free  (out_free),
		.ready     (ready),
		.res_valid (res_valid),
		.res       (res),
		.req       (req),
		.rd        (rd)
	);

	slpq_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd     (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {1'b0, res_q.rear_payload, res_q.front_payload, res_q.is_full,
		res_q.is_empty, res_q.entry_count, res_q.popped_priority, res_q.popped_payload};

endmodule

`default_nettype wire
